@@ design/als_pkg.sv @@
`default_nettype none

package als_pkg;

    // command codes
    localparam logic [1:0] CMD_FULL = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_RESP = 2'd2;

    // link status codes
    localparam logic [1:0] LINK_OK      = 2'd0;
    localparam logic [1:0] LINK_TIMEOUT = 2'd1;

    // sequencer phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WR_STATE = 3'd1;
    localparam logic [2:0] PH_POLL     = 3'd2;
    localparam logic [2:0] PH_CODE     = 3'd3;
    localparam logic [2:0] PH_WR_ACK   = 3'd4;
    localparam logic [2:0] PH_POLL_ACK = 3'd5;
    localparam logic [2:0] PH_OK       = 3'd6;
    localparam logic [2:0] PH_FAIL     = 3'd7;

    // outcome codes
    localparam logic [1:0] OUT_IDLE = 2'd0;
    localparam logic [1:0] OUT_BUSY = 2'd1;
    localparam logic [1:0] OUT_OK   = 2'd2;
    localparam logic [1:0] OUT_FAIL = 2'd3;

    // slave register offsets
    localparam logic [8:0] REG_CONTROL = 9'h120;
    localparam logic [8:0] REG_STATUS  = 9'h130;
    localparam logic [8:0] REG_CODE    = 9'h134;

    localparam logic [7:0] STATE_ERR_BIT = 8'h10;
    localparam logic [7:0] STATE_NIBBLE  = 8'h0F;

    // configuration register indexes
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_NO_ANSWER   = 2'd1;
    localparam logic [1:0] CFG_CHANGE      = 2'd2;

    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd3;
    localparam logic [31:0] NO_ANSWER_RST   = 32'd3000;
    localparam logic [31:0] CHANGE_RST      = 32'd5000;

    typedef struct packed {
        logic [3:0]  retry_limit;
        logic [31:0] no_answer_timeout;
        logic [31:0] change_timeout;
    } als_cfg_t;

    // tick fields travel separately, their width is a parameter
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] station_addr;
        logic [7:0]  req_state;
        logic [7:0]  known_state;
        logic [1:0]  link_status;
        logic [15:0] wkc;
        logic [15:0] read_data;
    } als_item_t;

    typedef struct packed {
        logic        send;
        logic        is_write;
        logic [8:0]  reg_offset;
        logic [15:0] target_station;
        logic [15:0] write_data;
        logic [1:0]  outcome;
        logic [7:0]  slave_state;
        logic [15:0] al_error_code;
        logic        refused;
        logic        spontaneous;
    } als_result_t;

endpackage

`default_nettype wire

@@ design/al_state_change_sequencer.sv @@
`default_nettype none

// Channel  Direction  Handshake               Contents
// in       input      in_valid / in_stall     cmd, station and states, response fields
// out      output     out_valid / out_stall   next access, outcome, slave status
// cfg      input      cfg_valid / cfg_ready   cfg_index (0..2), cfg_data
//
// An accepted item waits in the input register while the decision logic
// computes the next access from it; the result then moves into the result
// register once that register is empty or being emptied.
// Sustained rate is one item per cycle while out_stall is low; the result
// register and the input register each hold one transaction.
// rst_n clears all sequencer state and loads the register defaults
// (retries 3, no-answer timeout 3000, change timeout 5000).
// out_stall backs up into in_stall in the same cycle once both registers
// are full; cfg_ready is always high.
module al_state_change_sequencer
    import als_pkg::*;
#(
    parameter int TICK_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           cmd,
    input  wire logic [15:0]          station_addr,
    input  wire logic [7:0]           req_state,
    input  wire logic [7:0]           known_state,
    input  wire logic [1:0]           link_status,
    input  wire logic [15:0]          wkc,
    input  wire logic [15:0]          read_data,
    input  wire logic [TICK_BITS-1:0] tick_sent,
    input  wire logic [TICK_BITS-1:0] tick_received,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      send,
    output logic                      is_write,
    output logic [8:0]                reg_offset,
    output logic [15:0]               target_station,
    output logic [15:0]               write_data,
    output logic [1:0]                outcome,
    output logic [7:0]                slave_state,
    output logic [15:0]               al_error_code,
    output logic                      refused,
    output logic                      spontaneous,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data
);

    als_cfg_t             cfg;

    // input register
    logic                 in_valid_reg;
    als_item_t            item_reg;
    logic [TICK_BITS-1:0] sent_reg;
    logic [TICK_BITS-1:0] rx_reg;

    // result register
    logic                 out_valid_reg;
    als_result_t          res_reg;
    als_result_t          res;

    logic                 advance;
    logic                 in_take;

    // stage moves when the result slot is empty or being emptied
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    als_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // state is updated when the item leaves the input register
    als_core #(
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (in_valid_reg && advance),
        .item          (item_reg),
        .tick_sent     (sent_reg),
        .tick_received (rx_reg),
        .cfg           (cfg),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd          <= cmd;
            item_reg.station_addr <= station_addr;
            item_reg.req_state    <= req_state;
            item_reg.known_state  <= known_state;
            item_reg.link_status  <= link_status;
            item_reg.wkc          <= wkc;
            item_reg.read_data    <= read_data;
            sent_reg              <= tick_sent;
            rx_reg                <= tick_received;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign send           = res_reg.send;
    assign is_write       = res_reg.is_write;
    assign reg_offset     = res_reg.reg_offset;
    assign target_station = res_reg.target_station;
    assign write_data     = res_reg.write_data;
    assign outcome        = res_reg.outcome;
    assign slave_state    = res_reg.slave_state;
    assign al_error_code  = res_reg.al_error_code;
    assign refused        = res_reg.refused;
    assign spontaneous    = res_reg.spontaneous;

endmodule

`default_nettype wire

@@ design/als_cfg_regs.sv @@
`default_nettype none

module als_cfg_regs
    import als_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [31:0] wr_data,
    output als_cfg_t         cfg
);

    als_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit       <= RETRY_LIMIT_RST;
            cfg_reg.no_answer_timeout <= NO_ANSWER_RST;
            cfg_reg.change_timeout    <= CHANGE_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_RETRY_LIMIT: cfg_reg.retry_limit       <= wr_data[3:0];
                CFG_NO_ANSWER:   cfg_reg.no_answer_timeout <= wr_data;
                CFG_CHANGE:      cfg_reg.change_timeout    <= wr_data;
                default:         ; // unknown index: dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/als_core.sv @@
`default_nettype none

module als_core
    import als_pkg::*;
#(
    parameter int TICK_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step_en,
    input  wire als_item_t            item,
    input  wire logic [TICK_BITS-1:0] tick_sent,
    input  wire logic [TICK_BITS-1:0] tick_received,
    input  wire als_cfg_t             cfg,
    output als_result_t               res
);

    localparam int CMP_W = (TICK_BITS > 32) ? TICK_BITS : 32;

    logic [2:0]           phase_reg, phase_next;
    logic                 ack_only_reg, ack_only_next;
    logic [7:0]           target_reg, target_next;
    logic [7:0]           prior_reg, prior_next;
    logic [7:0]           current_reg, current_next;
    logic [15:0]          station_reg, station_next;
    logic [3:0]           retries_reg, retries_next;
    logic                 pending_reg, pending_next;
    logic [TICK_BITS-1:0] start_tick_reg, start_tick_next;
    logic                 spont_reg, spont_next;
    logic                 refused_reg, refused_next;
    logic [15:0]          code_reg, code_next;

    logic                 send;
    logic [7:0]           st;
    logic [TICK_BITS-1:0] start_eff;
    logic [TICK_BITS-1:0] elapsed;
    logic                 no_answer_expired;
    logic                 change_expired;
    logic                 wc_one;

    assign st        = item.read_data[7:0];
    assign wc_one    = (item.wkc == 16'd1);
    // a pending time mark takes the send tick of this response first
    assign start_eff = pending_reg ? tick_sent : start_tick_reg;
    assign elapsed   = tick_received - start_eff;
    assign no_answer_expired = CMP_W'(elapsed) >= CMP_W'(cfg.no_answer_timeout);
    assign change_expired    = CMP_W'(elapsed) >= CMP_W'(cfg.change_timeout);

    always_comb
    begin
        phase_next      = phase_reg;
        ack_only_next   = ack_only_reg;
        target_next     = target_reg;
        prior_next      = prior_reg;
        current_next    = current_reg;
        station_next    = station_reg;
        retries_next    = retries_reg;
        pending_next    = pending_reg;
        start_tick_next = start_tick_reg;
        spont_next      = spont_reg;
        refused_next    = refused_reg;
        code_next       = code_reg;
        send            = 1'b0;

        if (step_en)
        begin
            case (item.cmd)
                CMD_FULL, CMD_ACK:
                begin
                    station_next = item.station_addr;
                    current_next = item.known_state;
                    refused_next = 1'b0;
                    spont_next   = 1'b0;
                    retries_next = cfg.retry_limit;
                    send         = 1'b1;
                    if (item.cmd == CMD_FULL)
                    begin
                        ack_only_next = 1'b0;
                        target_next   = item.req_state;
                        prior_next    = item.known_state;
                        pending_next  = 1'b1;
                        phase_next    = PH_WR_STATE;
                    end
                    else
                    begin
                        ack_only_next = 1'b1;
                        target_next   = 8'h00;
                        phase_next    = PH_CODE;
                    end
                end
                CMD_RESP:
                begin
                    if (phase_reg >= PH_WR_STATE && phase_reg <= PH_POLL_ACK)
                    begin
                        if (item.link_status == LINK_TIMEOUT && retries_reg != 4'd0)
                        begin
                            retries_next = retries_reg - 4'd1;
                            send         = 1'b1;
                        end
                        else if (item.link_status != LINK_OK)
                        begin
                            phase_next = PH_FAIL;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_WR_STATE:
                                begin
                                    if (pending_reg)
                                    begin
                                        pending_next    = 1'b0;
                                        start_tick_next = tick_sent;
                                    end
                                    if (item.wkc == 16'd0)
                                    begin
                                        if (no_answer_expired)
                                            phase_next = PH_FAIL;
                                        else
                                        begin
                                            retries_next = cfg.retry_limit;
                                            send         = 1'b1;
                                        end
                                    end
                                    else if (!wc_one)
                                        phase_next = PH_FAIL;
                                    else
                                    begin
                                        pending_next = 1'b1;
                                        spont_next   = 1'b0;
                                        phase_next   = PH_POLL;
                                        retries_next = cfg.retry_limit;
                                        send         = 1'b1;
                                    end
                                end
                                PH_POLL:
                                begin
                                    if (!wc_one)
                                        phase_next = PH_FAIL;
                                    else
                                    begin
                                        if (pending_reg)
                                        begin
                                            pending_next    = 1'b0;
                                            start_tick_next = tick_sent;
                                        end
                                        current_next = st;
                                        if (st == target_reg)
                                            phase_next = PH_OK;
                                        else if (st != prior_reg)
                                        begin
                                            retries_next = cfg.retry_limit;
                                            send         = 1'b1;
                                            if ((st & STATE_NIBBLE) !=
                                                (prior_reg & STATE_NIBBLE))
                                            begin
                                                // slave moved on its own: follow it
                                                spont_next = 1'b1;
                                                prior_next = st;
                                            end
                                            else
                                            begin
                                                // same state with error flag: refused
                                                refused_next = 1'b1;
                                                phase_next   = PH_CODE;
                                            end
                                        end
                                        else if (change_expired)
                                            phase_next = PH_FAIL;
                                        else
                                        begin
                                            retries_next = cfg.retry_limit;
                                            send         = 1'b1;
                                        end
                                    end
                                end
                                PH_CODE:
                                begin
                                    code_next    = wc_one ? item.read_data : 16'h0000;
                                    phase_next   = PH_WR_ACK;
                                    retries_next = cfg.retry_limit;
                                    send         = 1'b1;
                                end
                                PH_WR_ACK:
                                begin
                                    if (!wc_one)
                                        phase_next = PH_FAIL;
                                    else
                                    begin
                                        pending_next = 1'b1;
                                        phase_next   = PH_POLL_ACK;
                                        retries_next = cfg.retry_limit;
                                        send         = 1'b1;
                                    end
                                end
                                PH_POLL_ACK:
                                begin
                                    if (!wc_one)
                                        phase_next = PH_FAIL;
                                    else
                                    begin
                                        if (pending_reg)
                                        begin
                                            pending_next    = 1'b0;
                                            start_tick_next = tick_sent;
                                        end
                                        current_next = st;
                                        if ((st & STATE_ERR_BIT) == 8'h00)
                                            phase_next = ack_only_reg ? PH_OK : PH_FAIL;
                                        else if (change_expired)
                                            phase_next = PH_FAIL;
                                        else
                                        begin
                                            retries_next = cfg.retry_limit;
                                            send         = 1'b1;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                default: ; // unused command code
            endcase
        end
    end

    // result built from the updated state
    always_comb
    begin
        res.send           = send;
        res.is_write       = 1'b0;
        res.reg_offset     = 9'h000;
        res.target_station = send ? station_next : 16'h0000;
        res.write_data     = 16'h0000;
        if (send)
        begin
            case (phase_next)
                PH_WR_STATE:
                begin
                    res.is_write   = 1'b1;
                    res.reg_offset = REG_CONTROL;
                    res.write_data = {8'h00, target_next};
                end
                PH_WR_ACK:
                begin
                    res.is_write   = 1'b1;
                    res.reg_offset = REG_CONTROL;
                    res.write_data = {8'h00, current_next};
                end
                PH_CODE: res.reg_offset = REG_CODE;
                default: res.reg_offset = REG_STATUS;
            endcase
        end
        case (phase_next)
            PH_IDLE: res.outcome = OUT_IDLE;
            PH_OK:   res.outcome = OUT_OK;
            PH_FAIL: res.outcome = OUT_FAIL;
            default: res.outcome = OUT_BUSY;
        endcase
        res.slave_state   = current_next;
        res.al_error_code = code_next;
        res.refused       = refused_next;
        res.spontaneous   = spont_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            ack_only_reg   <= 1'b0;
            target_reg     <= 8'h00;
            prior_reg      <= 8'h00;
            current_reg    <= 8'h00;
            station_reg    <= 16'h0000;
            retries_reg    <= 4'd0;
            pending_reg    <= 1'b0;
            start_tick_reg <= '0;
            spont_reg      <= 1'b0;
            refused_reg    <= 1'b0;
            code_reg       <= 16'h0000;
        end
        else
        begin
            phase_reg      <= phase_next;
            ack_only_reg   <= ack_only_next;
            target_reg     <= target_next;
            prior_reg      <= prior_next;
            current_reg    <= current_next;
            station_reg    <= station_next;
            retries_reg    <= retries_next;
            pending_reg    <= pending_next;
            start_tick_reg <= start_tick_next;
            spont_reg      <= spont_next;
            refused_reg    <= refused_next;
            code_reg       <= code_next;
        end
    end

    // full start always lands in the state write
    a_full_start: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.cmd == CMD_FULL |=> phase_reg == PH_WR_STATE)
        else $error("full start did not enter state write");

    // finished or idle sequencer ignores responses
    a_resp_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.cmd == CMD_RESP &&
        (phase_reg == PH_IDLE || phase_reg == PH_OK || phase_reg == PH_FAIL)
        |-> !res.send ##1 $stable(phase_reg))
        else $error("response acted on while not busy");

    // no access issued together with a final outcome
    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.send |-> res.outcome == OUT_BUSY)
        else $error("access issued with final outcome");

    // writes only ever go to the control register
    a_write_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        res.is_write |-> res.send && res.reg_offset == REG_CONTROL)
        else $error("write to a register other than control");

endmodule

`default_nettype wire

@@ tb/als_access_checker.sv @@
`default_nettype none

// Watches the command, result and register channels. Keeps its own copy of
// the sequencer, predicts one access per accepted command and compares it
// with the next accepted result.
module als_access_checker
    import als_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [15:0] station_addr,
    input  wire logic [7:0]  req_state,
    input  wire logic [7:0]  known_state,
    input  wire logic [1:0]  link_status,
    input  wire logic [15:0] wkc,
    input  wire logic [15:0] read_data,
    input  wire logic [31:0] tick_sent,
    input  wire logic [31:0] tick_received,

    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        send,
    input  wire logic        is_write,
    input  wire logic [8:0]  reg_offset,
    input  wire logic [15:0] target_station,
    input  wire logic [15:0] write_data,
    input  wire logic [1:0]  outcome,
    input  wire logic [7:0]  slave_state,
    input  wire logic [15:0] al_error_code,
    input  wire logic        refused,
    input  wire logic        spontaneous,

    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic [3:0]  lim_retry     = RETRY_LIMIT_RST;
    logic [31:0] lim_no_answer = NO_ANSWER_RST;
    logic [31:0] lim_change    = CHANGE_RST;

    // sequencer copy
    logic [2:0]  seq_ph   = PH_IDLE;
    logic        ack_mode = 1'b0;
    logic [7:0]  goal     = '0;
    logic [7:0]  prev_st  = '0;
    logic [7:0]  cur_st   = '0;
    logic [15:0] stn      = '0;
    logic [3:0]  retries  = '0;
    logic        armed    = 1'b0;
    logic [31:0] t_start  = '0;
    logic        spont    = 1'b0;
    logic        refusal  = 1'b0;
    logic [15:0] code     = '0;

    als_result_t expected_accesses[$];
    als_item_t   taken;
    als_result_t seen;
    als_result_t want;

    // new access in phase ph, retry budget reloaded
    function automatic void reenter(input logic [2:0] ph);
        seq_ph  = ph;
        retries = lim_retry;
    endfunction

    function automatic void mark_time(input logic [31:0] ts);
        if (armed)
        begin
            armed   = 1'b0;
            t_start = ts;
        end
    endfunction

    function automatic logic [31:0] ticks_since(input logic [31:0] tr);
        return tr - t_start;
    endfunction

    function automatic logic judge_response(input logic [1:0]  link,
                                            input logic [15:0] wc,
                                            input logic [15:0] data,
                                            input logic [31:0] ts,
                                            input logic [31:0] tr);
        logic [7:0] st;
        st = data[7:0];
        if (seq_ph < PH_WR_STATE || seq_ph > PH_POLL_ACK)
            return 1'b0;
        if (link == LINK_TIMEOUT && retries != 0)
        begin
            retries--;
            return 1'b1;
        end
        if (link != LINK_OK)
        begin
            seq_ph = PH_FAIL;
            return 1'b0;
        end
        case (seq_ph)
            PH_WR_STATE:
            begin
                mark_time(ts);
                if (wc == 0)
                begin
                    if (ticks_since(tr) >= lim_no_answer)
                    begin
                        seq_ph = PH_FAIL;
                        return 1'b0;
                    end
                    reenter(PH_WR_STATE);
                    return 1'b1;
                end
                if (wc > 1)
                begin
                    seq_ph = PH_FAIL;
                    return 1'b0;
                end
                armed = 1'b1;
                spont = 1'b0;
                reenter(PH_POLL);
                return 1'b1;
            end
            PH_POLL:
            begin
                if (wc != 1)
                begin
                    seq_ph = PH_FAIL;
                    return 1'b0;
                end
                mark_time(ts);
                cur_st = st;
                if (st == goal)
                begin
                    seq_ph = PH_OK;
                    return 1'b0;
                end
                if (st != prev_st)
                begin
                    // low nibble moved: slave went elsewhere by itself
                    if ((st & STATE_NIBBLE) != (prev_st & STATE_NIBBLE))
                    begin
                        spont   = 1'b1;
                        prev_st = st;
                        reenter(PH_POLL);
                        return 1'b1;
                    end
                    refusal = 1'b1;
                    reenter(PH_CODE);
                    return 1'b1;
                end
                if (ticks_since(tr) >= lim_change)
                begin
                    seq_ph = PH_FAIL;
                    return 1'b0;
                end
                reenter(PH_POLL);
                return 1'b1;
            end
            PH_CODE:
            begin
                code = (wc != 1) ? 16'h0000 : data;
                reenter(PH_WR_ACK);
                return 1'b1;
            end
            PH_WR_ACK:
            begin
                if (wc != 1)
                begin
                    seq_ph = PH_FAIL;
                    return 1'b0;
                end
                armed = 1'b1;
                reenter(PH_POLL_ACK);
                return 1'b1;
            end
            default:
            begin
                if (wc != 1)
                begin
                    seq_ph = PH_FAIL;
                    return 1'b0;
                end
                mark_time(ts);
                cur_st = st;
                if ((st & STATE_ERR_BIT) == 0)
                begin
                    // error cleared; a full change still counts as failed
                    seq_ph = ack_mode ? PH_OK : PH_FAIL;
                    return 1'b0;
                end
                if (ticks_since(tr) >= lim_change)
                begin
                    seq_ph = PH_FAIL;
                    return 1'b0;
                end
                reenter(PH_POLL_ACK);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic als_result_t next_access(input als_item_t it,
                                                input logic [31:0] ts,
                                                input logic [31:0] tr);
        als_result_t r;
        logic issue;
        r = '0;
        issue = 1'b0;
        if (it.cmd == CMD_FULL || it.cmd == CMD_ACK)
        begin
            stn     = it.station_addr;
            cur_st  = it.known_state;
            refusal = 1'b0;
            spont   = 1'b0;
            if (it.cmd == CMD_FULL)
            begin
                ack_mode = 1'b0;
                goal     = it.req_state;
                prev_st  = cur_st;
                armed    = 1'b1;
                reenter(PH_WR_STATE);
            end
            else
            begin
                ack_mode = 1'b1;
                goal     = '0;
                reenter(PH_CODE);
            end
            issue = 1'b1;
        end
        else if (it.cmd == CMD_RESP)
        begin
            issue = judge_response(it.link_status, it.wkc, it.read_data, ts, tr);
        end

        if (issue)
        begin
            r.send           = 1'b1;
            r.target_station = stn;
            case (seq_ph)
                PH_WR_STATE:
                begin
                    r.is_write   = 1'b1;
                    r.reg_offset = REG_CONTROL;
                    r.write_data = {8'h00, goal};
                end
                PH_WR_ACK:
                begin
                    r.is_write   = 1'b1;
                    r.reg_offset = REG_CONTROL;
                    r.write_data = {8'h00, cur_st};
                end
                PH_CODE:
                    r.reg_offset = REG_CODE;
                default:
                    r.reg_offset = REG_STATUS;
            endcase
        end

        case (seq_ph)
            PH_IDLE: r.outcome = OUT_IDLE;
            PH_OK:   r.outcome = OUT_OK;
            PH_FAIL: r.outcome = OUT_FAIL;
            default: r.outcome = OUT_BUSY;
        endcase
        r.slave_state   = cur_st;
        r.al_error_code = code;
        r.refused       = refusal;
        r.spontaneous   = spont;
        return r;
    endfunction

    function automatic void check_field(input string fname, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s mismatch: expected %h, got %h", $realtime, fname,
                         exp_v, got_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_retry     = RETRY_LIMIT_RST;
            lim_no_answer = NO_ANSWER_RST;
            lim_change    = CHANGE_RST;
            seq_ph        = PH_IDLE;
            ack_mode      = 1'b0;
            goal          = '0;
            prev_st       = '0;
            cur_st        = '0;
            stn           = '0;
            retries       = '0;
            armed         = 1'b0;
            t_start       = '0;
            spont         = 1'b0;
            refusal       = 1'b0;
            code          = '0;
            expected_accesses.delete();
            outstanding <= 0;
        end
        else
        begin
            // results first: one accepted at this edge can't belong to a
            // command accepted at the same edge
            if (out_valid && !out_stall)
            begin
                seen = '{send: send, is_write: is_write, reg_offset: reg_offset,
                         target_station: target_station, write_data: write_data,
                         outcome: outcome, slave_state: slave_state,
                         al_error_code: al_error_code, refused: refused,
                         spontaneous: spontaneous};
                if (expected_accesses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: send %b outcome %0d",
                                 $realtime, send, outcome);
                end
                else
                begin
                    want = expected_accesses.pop_front();
                    check_field("send", 32'(want.send), 32'(seen.send));
                    check_field("is_write", 32'(want.is_write), 32'(seen.is_write));
                    check_field("reg_offset", 32'(want.reg_offset), 32'(seen.reg_offset));
                    check_field("target_station", 32'(want.target_station),
                                32'(seen.target_station));
                    check_field("write_data", 32'(want.write_data), 32'(seen.write_data));
                    check_field("outcome", 32'(want.outcome), 32'(seen.outcome));
                    check_field("slave_state", 32'(want.slave_state),
                                32'(seen.slave_state));
                    check_field("al_error_code", 32'(want.al_error_code),
                                32'(seen.al_error_code));
                    check_field("refused", 32'(want.refused), 32'(seen.refused));
                    check_field("spontaneous", 32'(want.spontaneous),
                                32'(seen.spontaneous));
                end
            end

            if (in_valid && !in_stall)
            begin
                taken.cmd          = cmd;
                taken.station_addr = station_addr;
                taken.req_state    = req_state;
                taken.known_state  = known_state;
                taken.link_status  = link_status;
                taken.wkc          = wkc;
                taken.read_data    = read_data;
                expected_accesses.push_back(next_access(taken, tick_sent, tick_received));
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RETRY_LIMIT: lim_retry     = cfg_data[3:0];
                    CFG_NO_ANSWER:   lim_no_answer = cfg_data;
                    CFG_CHANGE:      lim_change    = cfg_data;
                    default: ;
                endcase
            end

            outstanding <= expected_accesses.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_al_state_change_sequencer.sv @@
`default_nettype none

// Top of the sequencer bench. It only produces stimulus and gives the
// verdict; als_access_checker sits beside the block, predicts every access
// and counts mismatches.
//
// Flow:
//   - reset, register defaults in force;
//   - a short directed run: ignored commands, retries, tick wraparound,
//     no-answer timeout, spontaneous change, refusal with code fetch and
//     acknowledge, change timeout, acknowledge-only starts, restart while busy;
//   - six random phases, each with its own register setting (extremes
//     included). Between phases the sender drains the block completely before
//     touching the registers.
// Both sides idle at random: mostly short gaps, a few long ones, and calm
// stretches with no gaps at all.
module tb_al_state_change_sequencer
    import als_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 1_000_000;

    // codes the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] LINK_OTHER = 2'd2;
    localparam logic [1:0] LINK_BAD   = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [15:0] station_addr;
    logic [7:0]  req_state;
    logic [7:0]  known_state;
    logic [1:0]  link_status;
    logic [15:0] wkc;
    logic [15:0] read_data;
    logic [31:0] tick_sent;
    logic [31:0] tick_received;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        send;
    logic        is_write;
    logic [8:0]  reg_offset;
    logic [15:0] target_station;
    logic [15:0] write_data;
    logic [1:0]  outcome;
    logic [7:0]  slave_state;
    logic [15:0] al_error_code;
    logic        refused;
    logic        spontaneous;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int          mismatches;
    int          outstanding;

    // stimulus bookkeeping
    int          items_sent;
    int          steady_left;  // transactions left in a no-gap stretch
    int          stall_left;
    int          calm_left;    // cycles left with no result stalls
    int          cycles;
    logic [31:0] tick_now;
    logic [31:0] cfg_na;       // register values as written, to aim ticks
    logic [31:0] cfg_chg;

    always #5 clk = ~clk;

    al_state_change_sequencer dut (.*);

    als_access_checker access_check (.*);

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // elapsed ticks: small, anywhere (wraps), or right at a timeout
    function automatic logic [31:0] pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 60);
        if (r < 80)
            return $urandom;
        if (r < 90)
            return cfg_chg + $urandom_range(0, 2) - 1;
        return cfg_na + $urandom_range(0, 2) - 1;
    endfunction

    function automatic als_item_t random_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(als_item_t)-1:0];
    endfunction

    // Result stalls: one assignment per falling edge.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 99) == 0)
                calm_left = $urandom_range(40, 200);
            else if ($urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    // One command transaction: payload at the falling edge, held until taken,
    // then an optional gap. Valid stays high into the next call when the gap
    // is zero.
    task automatic drive(input als_item_t it, input logic [31:0] ts, input logic [31:0] tr);
        int gap;
        @(negedge clk);
        cmd           <= it.cmd;
        station_addr  <= it.station_addr;
        req_state     <= it.req_state;
        known_state   <= it.known_state;
        link_status   <= it.link_status;
        wkc           <= it.wkc;
        read_data     <= it.read_data;
        tick_sent     <= ts;
        tick_received <= tr;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (steady_left > 0)
        begin
            steady_left--;
            gap = 0;
        end
        else
        begin
            gap = idle_len();
            if ($urandom_range(0, 60) == 0)
                steady_left = $urandom_range(30, 120);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic start_full(input logic [15:0] stn, input logic [7:0] goal,
                              input logic [7:0] known);
        als_item_t it;
        it = random_item();
        it.cmd          = CMD_FULL;
        it.station_addr = stn;
        it.req_state    = goal;
        it.known_state  = known;
        drive(it, $urandom, $urandom);
    endtask

    task automatic start_ack(input logic [15:0] stn, input logic [7:0] known);
        als_item_t it;
        it = random_item();
        it.cmd          = CMD_ACK;
        it.station_addr = stn;
        it.known_state  = known;
        drive(it, $urandom, $urandom);
    endtask

    task automatic respond(input logic [1:0] link, input logic [15:0] wc,
                           input logic [15:0] data, input logic [31:0] ts,
                           input logic [31:0] tr);
        als_item_t it;
        it = random_item();
        it.cmd         = CMD_RESP;
        it.link_status = link;
        it.wkc         = wc;
        it.read_data   = data;
        drive(it, ts, tr);
    endtask

    task automatic junk_command();
        als_item_t it;
        it = random_item();
        it.cmd = CMD_UNUSED;
        drive(it, $urandom, $urandom);
    endtask

    // Response with content that tends to move the sequence on: mostly a
    // good link and a working counter of one, slave states near the goal or
    // the last known state.
    task automatic random_response(input logic [7:0] goal, inout logic [7:0] known);
        logic [1:0]  link;
        logic [15:0] wc;
        logic [7:0]  st;
        logic [7:0]  hi;
        logic [31:0] ts;
        int r;

        r = $urandom_range(0, 99);
        if (r < 6)
            link = LINK_TIMEOUT;
        else if (r < 8)
            link = LINK_OTHER;
        else if (r < 9)
            link = LINK_BAD;
        else
            link = LINK_OK;

        r = $urandom_range(0, 99);
        if (r < 80)
            wc = 16'd1;
        else if (r < 90)
            wc = 16'd0;
        else if (r < 95)
            wc = 16'($urandom_range(2, 9));
        else
            wc = 16'($urandom);

        r = $urandom_range(0, 99);
        if (r < 20)
            st = goal;
        else if (r < 45)
            st = known;                     // no change yet
        else if (r < 60)
            st = known ^ STATE_ERR_BIT;     // same nibble: refusal
        else if (r < 70)
            st = known & ~STATE_ERR_BIT;    // error cleared
        else if (r < 85)
            st = known ^ {4'($urandom_range(1, 15)), 4'h0};
        else
            st = 8'($urandom);
        // a new low nibble becomes the slave's last known state half the time
        if ((st & STATE_NIBBLE) != (known & STATE_NIBBLE) && $urandom_range(0, 1) == 1)
            known = st;
        hi = 8'($urandom);

        if ($urandom_range(0, 49) == 0)
            tick_now = $urandom;
        else
            tick_now = tick_now + $urandom_range(1, 50);
        ts = tick_now;
        respond(link, wc, {hi, st}, ts, ts + pick_delta());
    endtask

    // One start followed by a run of responses; now and then noise instead.
    task automatic random_sequence();
        logic [15:0] stn;
        logic [7:0]  goal;
        logic [7:0]  known;
        int r;
        stn   = 16'($urandom);
        known = 8'($urandom);
        goal  = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 4)
            junk_command();
        else if (r < 20)
        begin
            goal = '0;
            start_ack(stn, known);
        end
        else
            start_full(stn, goal, known);
        repeat ($urandom_range(1, 14)) random_response(goal, known);
    endtask

    // Drop valid and hold off until every result is back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [3:0] retry, input logic [31:0] na,
                             input logic [31:0] chg, input int n);
        int stop;
        settle();
        write_reg(CFG_RETRY_LIMIT, {28'h0, retry});
        write_reg(CFG_NO_ANSWER, na);
        write_reg(CFG_CHANGE, chg);
        cfg_na  = na;
        cfg_chg = chg;
        stop = items_sent + n;
        while (items_sent < stop)
            random_sequence();
    endtask

    // Watchdog: a hang or a lost result ends the run here.
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("al_state_change_sequencer verification failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = CMD_RESP;
        station_addr  = '0;
        req_state     = '0;
        known_state   = '0;
        link_status   = LINK_OK;
        wkc           = '0;
        read_data     = '0;
        tick_sent     = '0;
        tick_received = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_RETRY_LIMIT;
        cfg_data      = '0;
        items_sent    = 0;
        steady_left   = 0;
        stall_left    = 0;
        calm_left     = 0;
        tick_now      = '0;
        cfg_na        = NO_ANSWER_RST;
        cfg_chg       = CHANGE_RST;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed, register defaults (3 retries, 3000, 5000) ---
        // nothing running: response and unused code both ignored
        respond(LINK_OK, 16'd1, 16'h0008, $urandom, $urandom);
        junk_command();

        // link timeout resend, zero-counter resend, no-answer timeout
        // reached across the tick wrap
        start_full(16'hFFFF, 8'h08, 8'h02);
        respond(LINK_TIMEOUT, 16'd1, 16'h0000, $urandom, $urandom);
        respond(LINK_OK, 16'd0, 16'h0000, 32'hFFFF_FFF0, 32'hFFFF_FFF8);
        respond(LINK_OK, 16'd0, 16'h0000, 32'd5, 32'd3000);

        // no change, spontaneous change, refusal, code fetch, acknowledge,
        // error still set, then cleared: full change ends failed
        start_full(16'h0000, 8'h04, 8'h01);
        respond(LINK_OK, 16'd1, 16'h0000, 32'd50, 32'd60);
        respond(LINK_OK, 16'd1, 16'hFF01, 32'd100, 32'd200);
        respond(LINK_OK, 16'd1, 16'h0002, 32'd110, 32'd210);
        respond(LINK_OK, 16'd1, 16'h0012, 32'd120, 32'd220);
        respond(LINK_OK, 16'd1, 16'hABCD, $urandom, $urandom);
        respond(LINK_OK, 16'd1, 16'h0000, $urandom, $urandom);
        respond(LINK_OK, 16'd1, 16'h0012, 32'd300, 32'd400);
        respond(LINK_OK, 16'd1, 16'h0002, 32'd310, 32'd410);

        // acknowledge only: failed code fetch, then bad counter on the ack
        start_ack(16'h1234, 8'h14);
        respond(LINK_OK, 16'd0, 16'h5555, $urandom, $urandom);
        respond(LINK_OK, 16'hFFFF, 16'h0000, $urandom, $urandom);

        // acknowledge only: error never clears, change timeout exactly hit
        start_ack(16'h8001, 8'h18);
        respond(LINK_OK, 16'd1, 16'h0BAD, $urandom, $urandom);
        respond(LINK_OK, 16'd1, 16'h0000, $urandom, $urandom);
        respond(LINK_OK, 16'd1, 16'hFF18, 32'd100, 32'd5100);

        // restart while busy, then a bad link status fails the new one
        start_full(16'h5A5A, 8'hF8, 8'h01);
        respond(LINK_OK, 16'd1, 16'h0000, $urandom, $urandom);
        start_full(16'hA5A5, 8'h08, 8'h01);
        respond(LINK_OK, 16'd1, 16'h0000, $urandom, $urandom);
        respond(LINK_BAD, 16'd1, 16'h0008, $urandom, $urandom);

        // --- random phases; settle() inside each drains the block first ---
        run_phase(4'd0, 32'd0, 32'd0, 240);
        run_phase(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 240);
        run_phase(4'($urandom_range(1, 4)), $urandom_range(5, 60), $urandom_range(5, 80), 240);
        run_phase(RETRY_LIMIT_RST, NO_ANSWER_RST, CHANGE_RST, 240);
        run_phase(4'($urandom), $urandom, $urandom_range(0, 200), 240);
        run_phase(4'd1, 32'd1, 32'h8000_0000, 240);

        settle();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("al_state_change_sequencer verification clean");
        else
            $display("al_state_change_sequencer verification failed");
        $finish;
    end

endmodule

`default_nettype wire
